@@ rtl/core/lz10_pkg.sv @@
// Shared types and constants for the LZ10 window decompressor.
// No dependencies; used by the top level by scoped names.
package lz10_pkg;

  localparam int unsigned WINDOW_SIZE = 4096;
  localparam int unsigned RING_AW     = $clog2(WINDOW_SIZE);
  localparam int unsigned FILL_CNT_W  = RING_AW + 1;

  localparam logic [RING_AW-1:0]    RING_START = RING_AW'(4078);
  localparam logic [FILL_CNT_W-1:0] RING_FULL  = FILL_CNT_W'(WINDOW_SIZE);
  localparam logic [7:0]            FILL_RESET = 8'hdf;

  // header phases
  localparam logic [3:0] PHASE_TAG   = 4'd0;
  localparam logic [3:0] PHASE_SIZE3 = 4'd4;
  localparam logic [3:0] PHASE_BODY  = 4'd8;

  localparam logic [3:0] FLAGS_PER_BYTE = 4'd8;
  localparam logic [4:0] MIN_MATCH      = 5'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LIT,
    S_RD,
    S_WR
  } state_t;

endpackage

@@ rtl/core/lz10_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lz10_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/lz10_window_decompressor.sv @@
// LZ10 (LZSS) window decompressor, top level.
// Depends on lz10_pkg and lz10_ram.
//
// Takes a compressed stream one byte per input request, header first (4
// bytes, or 8 with the extended size word), and delivers decompressed
// bytes one per output request. Header bytes, flag bytes and the first
// byte of a match produce nothing. A match copies L = 3..18 bytes: each is
// a read of the 4096-byte history RAM followed by its write-back, as the
// single registered read port needs. Output back-pressure can stall the
// work. The input is stalled while an item is in work. last_of_run marks
// the final byte delivered for one input request. stream_start restarts
// the block with no clearing pass: the ring is filled strictly in order
// from entry 4078, so a fill count tells which entries hold data; all
// others read as fill_byte. Bytes past the declared output size still
// enter the ring but are not delivered. The user must write fill_byte
// through cfg_we/cfg_wdata only while idle; the block does not check it.
module lz10_window_decompressor (
  input  logic       clk,
  input  logic       rst,
  // compressed input
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       stream_start,
  // decompressed output
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  // fill_byte register
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  localparam int unsigned AW = lz10_pkg::RING_AW;
  localparam int unsigned CW = lz10_pkg::FILL_CNT_W;

  lz10_pkg::state_t state, state_next;

  // stream state
  logic [7:0]    fill_byte;
  logic [AW-1:0] wr_pos, wr_pos_next;
  logic [CW-1:0] fill_cnt, fill_cnt_next;      // entries written since start
  logic [3:0]    header_phase, header_phase_next;
  logic [31:0]   output_size, output_size_next;
  logic [31:0]   emitted_count, emitted_count_next;
  logic [7:0]    token_flags, token_flags_next;
  logic [3:0]    flags_left, flags_left_next;
  logic [7:0]    pending_first, pending_first_next;
  logic          awaiting_second, awaiting_second_next;

  // per-item work registers
  logic [7:0]    lit_byte, lit_byte_next;
  logic [AW-1:0] src_pos, src_pos_next;
  logic [4:0]    remaining, remaining_next;

  // output register
  logic          out_valid_next;
  logic [7:0]    out_byte_next;
  logic          last_of_run_next;

  // shared produce path
  logic          prod_go;
  logic [7:0]    prod_val;
  logic          prod_last;
  logic          emit;
  logic          out_free;
  logic          src_marked;
  logic [AW-1:0] src_offs;
  logic [7:0]    ring_rdata;
  logic [AW-1:0] match_dist;
  logic [1:0]    size_lane;

  lz10_ram #(
    .WIDTH (8),
    .DEPTH (lz10_pkg::WINDOW_SIZE)
  ) u_ring (
    .clk   (clk),
    .we    (prod_go),
    .waddr (wr_pos),
    .wdata (prod_val),
    .raddr (src_pos),
    .rdata (ring_rdata)
  );

  assign in_stall   = (state != lz10_pkg::S_IDLE);
  assign out_free   = !out_valid || !out_stall;
  assign emit       = (emitted_count < output_size);
  // an entry holds data once the in-order fill has passed it
  assign src_offs   = src_pos - lz10_pkg::RING_START;
  assign src_marked = ({1'b0, src_offs} < fill_cnt);
  assign match_dist = {pending_first[3:0], in_byte};

  always_comb begin
    unique case (header_phase)
      4'd2, 4'd5: size_lane = 2'd1;
      4'd3, 4'd6: size_lane = 2'd2;
      4'd7:       size_lane = 2'd3;
      default:    size_lane = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lz10_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next           = state;
    wr_pos_next          = wr_pos;
    fill_cnt_next        = fill_cnt;
    header_phase_next    = header_phase;
    output_size_next     = output_size;
    emitted_count_next   = emitted_count;
    token_flags_next     = token_flags;
    flags_left_next      = flags_left;
    pending_first_next   = pending_first;
    awaiting_second_next = awaiting_second;
    lit_byte_next        = lit_byte;
    src_pos_next         = src_pos;
    remaining_next       = remaining;
    out_valid_next       = out_valid && out_stall;
    out_byte_next        = out_byte;
    last_of_run_next     = last_of_run;
    prod_go              = 1'b0;
    prod_val             = lit_byte;
    prod_last            = 1'b1;

    unique case (state)
      lz10_pkg::S_IDLE: begin
        if (in_valid) begin
          if (stream_start) begin
            // restart; this byte is header byte 0
            wr_pos_next          = lz10_pkg::RING_START;
            fill_cnt_next        = '0;
            header_phase_next    = 4'd1;
            output_size_next     = '0;
            emitted_count_next   = '0;
            token_flags_next     = '0;
            flags_left_next      = '0;
            pending_first_next   = '0;
            awaiting_second_next = 1'b0;
          end else if (header_phase < lz10_pkg::PHASE_BODY) begin
            if (header_phase == lz10_pkg::PHASE_TAG) begin
              header_phase_next = 4'd1;
            end else begin
              output_size_next = output_size | ({24'd0, in_byte} << {size_lane, 3'd0});
              header_phase_next = header_phase + 4'd1;
              // nonzero 24-bit size skips the extended size word
              if (header_phase_next == lz10_pkg::PHASE_SIZE3 && output_size_next != '0) begin
                header_phase_next = lz10_pkg::PHASE_BODY;
              end
            end
          end else if (flags_left == '0) begin
            token_flags_next = in_byte;
            flags_left_next  = lz10_pkg::FLAGS_PER_BYTE;
          end else if (!token_flags[7]) begin
            lit_byte_next    = in_byte;
            token_flags_next = {token_flags[6:0], 1'b0};
            flags_left_next  = flags_left - 4'd1;
            state_next       = lz10_pkg::S_LIT;
          end else if (!awaiting_second) begin
            pending_first_next   = in_byte;
            awaiting_second_next = 1'b1;
          end else begin
            src_pos_next         = wr_pos - match_dist - AW'(1);
            remaining_next       = {1'b0, pending_first[7:4]} + lz10_pkg::MIN_MATCH;
            pending_first_next   = '0;
            awaiting_second_next = 1'b0;
            token_flags_next     = {token_flags[6:0], 1'b0};
            flags_left_next      = flags_left - 4'd1;
            state_next           = lz10_pkg::S_RD;
          end
        end
      end

      lz10_pkg::S_LIT: begin
        if (!emit || out_free) begin
          prod_go    = 1'b1;
          prod_val   = lit_byte;
          prod_last  = 1'b1;
          state_next = lz10_pkg::S_IDLE;
        end
      end

      lz10_pkg::S_RD: begin
        state_next = lz10_pkg::S_WR;
      end

      lz10_pkg::S_WR: begin
        // read data stays put while waiting: source address is held
        if (!emit || out_free) begin
          prod_go        = 1'b1;
          prod_val       = src_marked ? ring_rdata : fill_byte;
          prod_last      = (remaining == 5'd1) || (emitted_count == output_size - 32'd1);
          src_pos_next   = src_pos + AW'(1);
          remaining_next = remaining - 5'd1;
          state_next     = (remaining == 5'd1) ? lz10_pkg::S_IDLE : lz10_pkg::S_RD;
        end
      end

      default: begin
        state_next = lz10_pkg::S_IDLE;
      end
    endcase

    if (prod_go) begin
      wr_pos_next = wr_pos + AW'(1);
      if (fill_cnt != lz10_pkg::RING_FULL) begin
        fill_cnt_next = fill_cnt + CW'(1);
      end
      if (emitted_count != 32'hffff_ffff) begin
        emitted_count_next = emitted_count + 32'd1;
      end
      if (emit) begin
        out_valid_next   = 1'b1;
        out_byte_next    = prod_val;
        last_of_run_next = prod_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_byte       <= lz10_pkg::FILL_RESET;
      wr_pos          <= lz10_pkg::RING_START;
      fill_cnt        <= '0;
      header_phase    <= lz10_pkg::PHASE_TAG;
      output_size     <= '0;
      emitted_count   <= '0;
      token_flags     <= '0;
      flags_left      <= '0;
      pending_first   <= '0;
      awaiting_second <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        fill_byte <= cfg_wdata;
      end
      wr_pos          <= wr_pos_next;
      fill_cnt        <= fill_cnt_next;
      header_phase    <= header_phase_next;
      output_size     <= output_size_next;
      emitted_count   <= emitted_count_next;
      token_flags     <= token_flags_next;
      flags_left      <= flags_left_next;
      pending_first   <= pending_first_next;
      awaiting_second <= awaiting_second_next;
      out_valid       <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    lit_byte    <= lit_byte_next;
    src_pos     <= src_pos_next;
    remaining   <= remaining_next;
    out_byte    <= out_byte_next;
    last_of_run <= last_of_run_next;
  end

endmodule

@@ sim/tb_top.sv @@
// Testbench for lz10_window_decompressor: a directed run and then random compressed streams.
// Accepted output bytes are checked against an LZ10 decoder in this bench, or typed rows.
// Depends on lz10_pkg and the lz10_window_decompressor RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIR_ROWS        = 25;
  localparam int RANDOM_REQUESTS = 100;
  localparam int SETTLE_CYCLES   = 64;   // room for the longest match (18 bytes), plus margin
  localparam int CYCLE_LIMIT     = 2_000_000;

  // one decoded byte as the output port shows it
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_rec_t;

  // directed row: typed rows carry n copies of v as the expected bytes,
  // the others take whatever the decoder model works out
  typedef struct packed {
    logic [7:0] b;
    logic       s;
    logic       typed;
    logic [4:0] n;
    logic [7:0] v;
  } stim_row_t;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte      = 8'h00;
  logic       stream_start = 1'b0;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       cfg_we       = 1'b0;
  logic [7:0] cfg_wdata    = 8'h00;

  lz10_window_decompressor i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .stream_start (stream_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Decoder model: window, written marks and token parser state
  // ---------------------------------------------------------------------------
  logic [7:0]  ring_mem  [lz10_pkg::WINDOW_SIZE];
  bit          ring_mark [lz10_pkg::WINDOW_SIZE];
  logic [11:0] wr_pos;
  logic [3:0]  hdr_phase;
  logic [31:0] out_size;
  logic [31:0] emitted;
  logic [7:0]  flag_bits;
  logic [3:0]  flags_left;
  logic [7:0]  match_hi;
  bit          have_hi;
  logic [7:0]  fill_val;

  out_rec_t step_bytes[$];      // bytes produced by the request just decoded
  out_rec_t expected_bytes[$];  // bytes still owed by the DUT, oldest first

  int  mismatches    = 0;
  int  requests_sent = 0;
  int  hold_req      = 0;   // long receiver hold-off, consumed by the stall process
  bit  calm          = 1'b0; // no gaps and no stalls while set
  longint cycles     = 0;

  function automatic void restart_decoder();
    foreach (ring_mark[i]) ring_mark[i] = 1'b0;
    wr_pos     = lz10_pkg::RING_START;
    hdr_phase  = lz10_pkg::PHASE_TAG;
    out_size   = '0;
    emitted    = '0;
    flag_bits  = '0;
    flags_left = '0;
    match_hi   = '0;
    have_hi    = 1'b0;
  endfunction

  // every produced byte lands in the window; only bytes within the declared size go out
  function automatic void put_byte(logic [7:0] v);
    ring_mem[wr_pos]  = v;
    ring_mark[wr_pos] = 1'b1;
    wr_pos++;
    if (emitted < out_size) step_bytes.push_back('{data: v, last: 1'b0});
    if (emitted != '1) emitted++;
  endfunction

  function automatic void next_flag();
    flag_bits = flag_bits << 1;
    if (flags_left != 0) flags_left--;
  endfunction

  function automatic void decode_request(logic [7:0] b, logic s);
    logic [11:0] distance;
    logic [11:0] src;
    int          len;
    step_bytes.delete();
    if (s) restart_decoder();
    if (hdr_phase < lz10_pkg::PHASE_BODY) begin
      if (hdr_phase == lz10_pkg::PHASE_TAG) begin
        hdr_phase++;                    // tag byte is not checked
      end else if (hdr_phase < lz10_pkg::PHASE_SIZE3) begin
        out_size |= 32'(b) << (8 * (hdr_phase - 1));
        hdr_phase++;
        // a zero 24-bit size means four more size bytes follow
        if (hdr_phase == lz10_pkg::PHASE_SIZE3 && out_size != 0)
          hdr_phase = lz10_pkg::PHASE_BODY;
      end else begin
        out_size |= 32'(b) << (8 * (hdr_phase - lz10_pkg::PHASE_SIZE3));
        hdr_phase++;
      end
    end else if (flags_left == 0) begin
      flag_bits  = b;
      flags_left = lz10_pkg::FLAGS_PER_BYTE;
    end else if (!flag_bits[7]) begin
      put_byte(b);
      next_flag();
    end else if (!have_hi) begin
      match_hi = b;
      have_hi  = 1'b1;
    end else begin
      distance = {match_hi[3:0], b};
      len      = match_hi[7:4] + lz10_pkg::MIN_MATCH;
      for (int k = 0; k < len; k++) begin
        src = wr_pos - distance - 12'd1;
        put_byte(ring_mark[src] ? ring_mem[src] : fill_val);
      end
      have_hi  = 1'b0;
      match_hi = '0;
      next_flag();
    end
    if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle lengths: mostly none or short, now and then a long one
  // ---------------------------------------------------------------------------
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. A request is offered after a random gap and held until taken;
  // the model runs at the accepting edge. Typed rows queue their own bytes.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [7:0] b, input logic s, input logic typed = 1'b0,
                              input int n = 0, input logic [7:0] v = 8'h00);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_byte      <= b;
    stream_start <= s;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    decode_request(b, s);
    if (typed) begin
      for (int k = 0; k < n; k++) expected_bytes.push_back('{data: v, last: (k == n - 1)});
    end else begin
      foreach (step_bytes[k]) expected_bytes.push_back(step_bytes[k]);
    end
    requests_sent++;
  endtask

  // One compressed stream: header (short or extended size), then tokens in
  // groups of eight behind a flag byte. Long runs use 18-byte matches only,
  // enough to carry the write pointer past the top of the window.
  task automatic send_stream(input int tokens, input bit long_run);
    logic [31:0] size;
    logic [7:0]  flags;
    logic [7:0]  hi;
    logic [11:0] distance;
    bit          ext;
    int          r;
    r = $urandom_range(0, 9);
    if (long_run)   size = 32'h00ff_ffff;
    else if (r < 6) size = $urandom_range(1, 400);
    else if (r < 8) size = $urandom_range(1, 20);   // output cut short
    else if (r < 9) size = $urandom;
    else            size = '0;                       // nothing goes out
    ext = !long_run && (size == 0 || size[31:24] != 0 || $urandom_range(0, 4) == 0);
    // now and then no start mark: the bytes land in whatever state is left
    send_request(8'($urandom), long_run || $urandom_range(0, 9) != 0);
    if (ext) begin
      repeat (3) send_request(8'h00, 1'b0);
      for (int i = 0; i < 4; i++) send_request(size[8*i +: 8], 1'b0);
    end else begin
      for (int i = 0; i < 3; i++) send_request(size[8*i +: 8], 1'b0);
    end
    flags = '0;
    for (int t = 0; t < tokens; t++) begin
      if (t % 8 == 0) begin
        flags = long_run ? 8'hff : 8'($urandom);
        send_request(flags, 1'b0);
      end
      if (!flags[7]) begin
        send_request(8'($urandom), 1'b0);
      end else begin
        // mostly short distances into fresh data, sometimes anywhere in the window
        distance = (long_run || $urandom_range(0, 3) == 0) ? 12'($urandom)
                                                           : 12'($urandom_range(0, 40));
        hi = {long_run ? 4'hf : 4'($urandom), distance[11:8]};
        send_request(hi, 1'b0);
        // a stream may end between the two match bytes
        if (t < tokens - 1 || $urandom_range(0, 7) != 0) send_request(distance[7:0], 1'b0);
      end
      flags = flags << 1;
    end
  endtask

  // Drain: every owed byte out, then room for a request that makes no output.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_fill(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    fill_val   = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall runs, plus the long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : rx_stall
    int run_left;
    run_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        run_left = hold_req;
        hold_req = 0;
      end else if (run_left == 0 && !calm && $urandom_range(0, 2) == 0) begin
        run_left = idle_len();
      end
      if (run_left > 0) begin
        out_stall <= 1'b1;
        run_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // values sampled at the edge are the ones the DUT saw
  always @(posedge clk) begin : out_check
    out_rec_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected output, out_byte %02h last_of_run %0b",
                 $time, out_byte, last_of_run);
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.data) begin
          mismatches++;
          $display("%0t: out_byte expected %02h got %02h", $time, want.data, out_byte);
        end
        if (last_of_run !== want.last) begin
          mismatches++;
          $display("%0t: last_of_run expected %0b got %0b", $time, want.last, last_of_run);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("lz10_window_decompressor test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t dir_rows [0:DIR_ROWS-1];
    int        phase;
    dir_rows = '{
      // first stream, no start mark after reset; fill byte still at its reset value
      '{8'h00, 1'b0, 1'b1, 5'd0,  8'h00},  // tag
      '{8'h0a, 1'b0, 1'b1, 5'd0,  8'h00},  // size = 10
      '{8'h00, 1'b0, 1'b1, 5'd0,  8'h00},
      '{8'h00, 1'b0, 1'b1, 5'd0,  8'h00},
      '{8'h5f, 1'b0, 1'b1, 5'd0,  8'h00},  // flags: lit, match, lit, match x5
      '{8'h00, 1'b0, 1'b1, 5'd1,  8'h00},  // literal 00
      '{8'h00, 1'b0, 1'b1, 5'd0,  8'h00},  // match, length 3, distance 0
      '{8'h00, 1'b0, 1'b1, 5'd3,  8'h00},
      '{8'hff, 1'b0, 1'b1, 5'd1,  8'hff},  // literal ff
      '{8'h0f, 1'b0, 1'b1, 5'd0,  8'h00},  // match, distance fff: unwritten entries
      '{8'hff, 1'b0, 1'b1, 5'd3,  lz10_pkg::FILL_RESET},
      '{8'hf0, 1'b0, 1'b1, 5'd0,  8'h00},  // match, length 18, runs past the size
      '{8'h00, 1'b0, 1'b0, 5'd0,  8'h00},
      '{8'h10, 1'b0, 1'b1, 5'd0,  8'h00},  // match wholly past the size
      '{8'h05, 1'b0, 1'b0, 5'd0,  8'h00},
      // restart mid-stream, extended size header, largest size
      '{8'hff, 1'b1, 1'b1, 5'd0,  8'h00},
      '{8'h00, 1'b0, 1'b1, 5'd0,  8'h00},
      '{8'h00, 1'b0, 1'b1, 5'd0,  8'h00},
      '{8'h00, 1'b0, 1'b1, 5'd0,  8'h00},
      '{8'hff, 1'b0, 1'b1, 5'd0,  8'h00},
      '{8'hff, 1'b0, 1'b1, 5'd0,  8'h00},
      '{8'hff, 1'b0, 1'b1, 5'd0,  8'h00},
      '{8'hff, 1'b0, 1'b1, 5'd0,  8'h00},
      '{8'h00, 1'b0, 1'b1, 5'd0,  8'h00},  // flags: all literals
      '{8'h80, 1'b0, 1'b1, 5'd1,  8'h80}
    };
    fill_val = lz10_pkg::FILL_RESET;
    restart_decoder();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_request(dir_rows[i].b, dir_rows[i].s, dir_rows[i].typed,
                   dir_rows[i].n, dir_rows[i].v);

    // random streams, a new fill byte before each one
    phase = 1;
    while (requests_sent < DIR_ROWS + RANDOM_REQUESTS) begin
      settle();
      case (phase)
        1: write_fill(8'h00);
        2: write_fill(8'hff);
        default: write_fill(8'($urandom));
      endcase
      calm = (phase == 2);
      // receiver holds off while requests keep coming: the DUT must stall its input
      if (phase == 1) hold_req = 400;
      send_stream($urandom_range(4, 20), 1'b0);
      phase++;
    end

    // one stream of longest matches, carrying the write pointer past the window top;
    // the receiver holds off at its start so the output fills and the input stalls
    settle();
    calm = 1'b0;
    write_fill(8'($urandom));
    hold_req = 400;
    send_stream(40, 1'b1);

    settle();
    if (mismatches == 0) begin
      $display("lz10_window_decompressor test passed");
    end else begin
      $display("lz10_window_decompressor test failed");
    end
    $finish;
  end

endmodule

@@ lz10_window_decompressor.f @@
rtl/core/lz10_pkg.sv
rtl/core/lz10_ram.sv
rtl/core/lz10_window_decompressor.sv
sim/tb_top.sv
